/* hw/rtl/fixtvp_pkg.sv */
package fixtvp_pkg;

  // Port widths
  localparam int FIELD_W          = 20;
  localparam int CFG_W            = 20;
  localparam int STATUS_W         = 3;
  localparam int LENGTH_WIDTH_DEF = 20;

  localparam logic [CFG_W-1:0] SIZE_LIMIT_RST = 20'd4096;

  // Frame counter saturates here
  localparam int               FRAME_CNT_W   = 21;
  localparam logic [FRAME_CNT_W-1:0] FRAME_CNT_MAX = '1;

  // Characters of the tag/value syntax
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESYNC   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CKSUM    = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  frame_bytes;
    logic [FIELD_W-1:0]  body_offset;
    logic [FIELD_W-1:0]  body_bytes;
  } result_t;

  function automatic logic is_dec(input logic [7:0] b);
    is_dec = (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

/* hw/rtl/fix_tag_value_frame_parser_top.sv */
// Tag/value frame parser for a FIX-style byte stream. One byte per transaction goes in on
// the in_ channel; the block checks the begin string "8=...<SOH>", the "9=<digits><SOH>"
// body length (bounded by the frame size limit written on cfg_wr_data, reset value 4096),
// counts off the body, whose last byte must be SOH, and checks the "10=ddd<SOH>" trailer
// against a mod-256 sum of all bytes ahead of the trailer tag. Exactly one result
// transaction is issued per frame: status 0 with frame length, body offset and body
// length on success, or an error status (1 resync, 2 bad body length/tag, 3 too large,
// 4 checksum) with zeroed lengths at the byte that decides the error; the parser then
// expects '8' again.
// Throughput is one byte per clock while the result register is not stalled. A byte accepted
// into the input register is folded into the frame state by the combinational parser update,
// and its result (if any) is loaded into the result register that drives out_. A
// stalled result register blocks further bytes only while it is still full and not being
// taken. Write the size limit only while no byte is in flight.
module fix_tag_value_frame_parser_top #(
  parameter int LENGTH_WIDTH = fixtvp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Byte input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fixtvp_pkg::STATUS_W-1:0] out_status,
  output logic [fixtvp_pkg::FIELD_W-1:0]  out_frame_len,
  output logic [fixtvp_pkg::FIELD_W-1:0]  out_body_offset,
  output logic [fixtvp_pkg::FIELD_W-1:0]  out_body_len,
  // Configuration
  input  logic                            cfg_wr_en,
  input  logic [fixtvp_pkg::CFG_W-1:0]    cfg_wr_data
);
  import fixtvp_pkg::*;

  logic [CFG_W-1:0] mfb_r;
  logic [CFG_W-1:0] mfb_nxt;
  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             can_load;
  logic             step;
  logic             res_valid;
  result_t          res;

  // Configuration register: take the write data whenever the enable is high
  assign mfb_nxt = cfg_wr_en ? cfg_wr_data : mfb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mfb_r <= SIZE_LIMIT_RST;
    end else begin
      mfb_r <= mfb_nxt;
    end
  end

  // Advance the held byte through the parser whenever the result register can take
  // whatever it produces
  assign step = hold_valid && can_load;

  fixtvp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .take         (step),
    .hold_valid   (hold_valid),
    .hold_byte    (hold_byte)
  );

  fixtvp_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (hold_byte),
    .size_limit (mfb_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  fixtvp_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step && res_valid),
    .res_i           (res),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_frame_len   (out_frame_len),
    .out_body_offset (out_body_offset),
    .out_body_len    (out_body_len)
  );

  // Error results carry no lengths
  a_err_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_frame_len == '0 && out_body_offset == '0 && out_body_len == '0))
    else $error("error result with nonzero length fields");

  // A good frame has a nonempty body that starts inside the frame
  a_ok_geometry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_body_len != '0 && out_body_offset < out_frame_len))
    else $error("completed frame with inconsistent body geometry");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_CKSUM))
    else $error("undefined result status");

  // Input back-pressure only comes from a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (hold_valid && out_valid && !out_ready))
    else $error("input stalled without a full result register");

  // Hold the limit register unless it is written
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr_en |=> $stable(mfb_r))
    else $error("limit register changed without a write");

endmodule

/* hw/rtl/fixtvp_in_reg.sv */
module fixtvp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);
  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !vld_r || take;
  assign hold_valid = vld_r;
  assign hold_byte  = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
    end
  end

endmodule

/* hw/rtl/fixtvp_parser.sv */
module fixtvp_parser #(
  parameter int LENGTH_WIDTH = fixtvp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [7:0]                   data_byte,
  input  logic [fixtvp_pkg::CFG_W-1:0] size_limit,
  output logic                         res_valid,
  output fixtvp_pkg::result_t          res
);
  import fixtvp_pkg::*;

  localparam int LW = LENGTH_WIDTH;
  localparam int PW = LENGTH_WIDTH + 1;
  localparam int CW = (LENGTH_WIDTH > CFG_W) ? LENGTH_WIDTH : CFG_W;

  localparam logic [3:0] PH_EXP8  = 4'd0;
  localparam logic [3:0] PH_EXPEQ = 4'd1;
  localparam logic [3:0] PH_BEGIN = 4'd2;
  localparam logic [3:0] PH_TAG9  = 4'd3;
  localparam logic [3:0] PH_TAGEQ = 4'd4;
  localparam logic [3:0] PH_LEN   = 4'd5;
  localparam logic [3:0] PH_BODY  = 4'd6;
  localparam logic [3:0] PH_CK1   = 4'd7;
  localparam logic [3:0] PH_CK0   = 4'd8;
  localparam logic [3:0] PH_CKEQ  = 4'd9;
  localparam logic [3:0] PH_CKD   = 4'd10;
  localparam logic [3:0] PH_CKSOH = 4'd11;

  localparam logic [PW-1:0] POS_CAP = '1;
  localparam logic [CW-1:0] LEN_CAP = CW'({LW{1'b1}});

  logic [3:0]             phase_r, phase_nxt;
  logic [FRAME_CNT_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [LW-1:0]          decl_len_r, decl_len_nxt;
  logic [LW-1:0]          body_rem_r, body_rem_nxt;
  logic [PW-1:0]          body_start_r, body_start_nxt;
  logic [7:0]             run_sum_r, run_sum_nxt;
  logic [9:0]             ck_val_r, ck_val_nxt;
  logic [1:0]             digit_cnt_r, digit_cnt_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [STATUS_W-1:0]    len_err_r, len_err_nxt;
  logic                   tag_bad_r, tag_bad_nxt;
  logic                   digit_bad_r, digit_bad_nxt;

  logic [CW-1:0]          mfb_ext;
  logic [CW-1:0]          lim_ext;
  logic [LW-1:0]          lim;
  logic [PW-1:0]          pos_inc;
  logic [LW+3:0]          len_acc;
  logic [13:0]            ck_acc;
  logic [LW-1:0]          rem_dec;
  logic                   fin;
  logic                   clr;
  logic [STATUS_W-1:0]    st;
  logic                   ok;

  // Limit is the register clamped to the length width
  assign mfb_ext = CW'(size_limit);
  assign lim_ext = (mfb_ext < LEN_CAP) ? mfb_ext : LEN_CAP;
  assign lim     = lim_ext[LW-1:0];

  assign pos_inc = (pos_r == POS_CAP) ? pos_r : pos_r + 1'b1;
  assign len_acc = (LW+4)'({decl_len_r, 3'b000}) + (LW+4)'({decl_len_r, 1'b0})
                 + (LW+4)'(data_byte[3:0]);
  assign ck_acc  = 14'({ck_val_r, 3'b000}) + 14'({ck_val_r, 1'b0}) + 14'(data_byte[3:0]);
  assign rem_dec = (body_rem_r != '0) ? body_rem_r - 1'b1 : body_rem_r;

  always_comb begin
    phase_nxt      = phase_r;
    frame_cnt_nxt  = frame_cnt_r;
    decl_len_nxt   = decl_len_r;
    body_rem_nxt   = body_rem_r;
    body_start_nxt = body_start_r;
    run_sum_nxt    = run_sum_r;
    ck_val_nxt     = ck_val_r;
    digit_cnt_nxt  = digit_cnt_r;
    pos_nxt        = pos_r;
    len_err_nxt    = len_err_r;
    tag_bad_nxt    = tag_bad_r;
    digit_bad_nxt  = digit_bad_r;
    fin            = 1'b0;
    clr            = 1'b0;
    st             = ST_OK;
    ok             = 1'b0;

    if (step) begin
      if (phase_r <= PH_BODY) begin
        run_sum_nxt = run_sum_r + data_byte;
      end
      case (phase_r)
        PH_EXP8: begin
          if (data_byte != CH_EIGHT) begin
            fin = 1'b1;
            st  = ST_RESYNC;
          end else begin
            phase_nxt = PH_EXPEQ;
          end
        end
        PH_EXPEQ: begin
          if (data_byte != CH_EQ) begin
            fin = 1'b1;
            st  = ST_RESYNC;
          end else begin
            phase_nxt = PH_BEGIN;
          end
        end
        PH_BEGIN: begin
          if (data_byte == CH_SOH) begin
            phase_nxt = PH_TAG9;
          end
        end
        PH_TAG9: begin
          tag_bad_nxt = (data_byte != CH_NINE);
          phase_nxt   = PH_TAGEQ;
        end
        PH_TAGEQ: begin
          if (tag_bad_r || data_byte != CH_EQ) begin
            fin = 1'b1;
            st  = ST_BAD_LEN;
          end else begin
            decl_len_nxt = '0;
            len_err_nxt  = ST_OK;
            phase_nxt    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (data_byte == CH_SOH) begin
            if (len_err_r != ST_OK) begin
              fin = 1'b1;
              st  = len_err_r;
            end else if (decl_len_r == '0) begin
              fin = 1'b1;
              st  = ST_BAD_LEN;
            end else begin
              body_start_nxt = pos_inc;
              body_rem_nxt   = decl_len_r;
              tag_bad_nxt    = 1'b0;
              phase_nxt      = PH_BODY;
            end
          end else if (len_err_r == ST_OK) begin
            if (!is_dec(data_byte)) begin
              len_err_nxt = ST_BAD_LEN;
            end else if (len_acc > (LW+4)'(lim)) begin
              len_err_nxt = ST_TOO_BIG;
            end else begin
              decl_len_nxt = len_acc[LW-1:0];
            end
          end
        end
        PH_BODY: begin
          body_rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            if (data_byte != CH_SOH) begin
              tag_bad_nxt = 1'b1;
            end
            phase_nxt = PH_CK1;
          end
        end
        PH_CK1: begin
          if (data_byte != CH_ONE) begin
            tag_bad_nxt = 1'b1;
          end
          phase_nxt = PH_CK0;
        end
        PH_CK0: begin
          if (data_byte != CH_ZERO) begin
            tag_bad_nxt = 1'b1;
          end
          phase_nxt = PH_CKEQ;
        end
        PH_CKEQ: begin
          if (data_byte != CH_EQ) begin
            tag_bad_nxt = 1'b1;
          end
          ck_val_nxt    = '0;
          digit_cnt_nxt = '0;
          digit_bad_nxt = 1'b0;
          phase_nxt     = PH_CKD;
        end
        PH_CKD: begin
          if (is_dec(data_byte)) begin
            ck_val_nxt = ck_acc[9:0];
          end else begin
            digit_bad_nxt = 1'b1;
          end
          digit_cnt_nxt = digit_cnt_r + 1'b1;
          if (digit_cnt_nxt == 2'd3) begin
            phase_nxt = PH_CKSOH;
          end
        end
        PH_CKSOH: begin
          fin = 1'b1;
          if (tag_bad_r) begin
            st = ST_BAD_LEN;
          end else if (digit_bad_r || data_byte != CH_SOH || ck_val_r != {2'b00, run_sum_r}) begin
            st = ST_CKSUM;
          end else if (pos_inc > {1'b0, lim}) begin
            st = ST_TOO_BIG;
          end else begin
            st = ST_OK;
            ok = 1'b1;
            if (frame_cnt_r != FRAME_CNT_MAX) begin
              frame_cnt_nxt = frame_cnt_r + 1'b1;
            end
          end
        end
        default: begin
          clr = 1'b1;
        end
      endcase

      if (fin || clr) begin
        phase_nxt      = PH_EXP8;
        decl_len_nxt   = '0;
        body_rem_nxt   = '0;
        body_start_nxt = '0;
        run_sum_nxt    = '0;
        ck_val_nxt     = '0;
        digit_cnt_nxt  = '0;
        pos_nxt        = '0;
        len_err_nxt    = ST_OK;
        tag_bad_nxt    = 1'b0;
        digit_bad_nxt  = 1'b0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  assign res_valid       = fin;
  assign res.status      = st;
  assign res.frame_bytes = ok ? FIELD_W'(pos_inc)      : '0;
  assign res.body_offset = ok ? FIELD_W'(body_start_r) : '0;
  assign res.body_bytes  = ok ? FIELD_W'(decl_len_r)   : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_EXP8;
      frame_cnt_r  <= '0;
      decl_len_r   <= '0;
      body_rem_r   <= '0;
      body_start_r <= '0;
      run_sum_r    <= '0;
      ck_val_r     <= '0;
      digit_cnt_r  <= '0;
      pos_r        <= '0;
      len_err_r    <= ST_OK;
      tag_bad_r    <= 1'b0;
      digit_bad_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      decl_len_r   <= decl_len_nxt;
      body_rem_r   <= body_rem_nxt;
      body_start_r <= body_start_nxt;
      run_sum_r    <= run_sum_nxt;
      ck_val_r     <= ck_val_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      pos_r        <= pos_nxt;
      len_err_r    <= len_err_nxt;
      tag_bad_r    <= tag_bad_nxt;
      digit_bad_r  <= digit_bad_nxt;
    end
  end

endmodule

/* hw/rtl/fixtvp_out_reg.sv */
module fixtvp_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  fixtvp_pkg::result_t                 res_i,
  output logic                                can_load,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fixtvp_pkg::STATUS_W-1:0]     out_status,
  output logic [fixtvp_pkg::FIELD_W-1:0]      out_frame_len,
  output logic [fixtvp_pkg::FIELD_W-1:0]      out_body_offset,
  output logic [fixtvp_pkg::FIELD_W-1:0]      out_body_len
);
  import fixtvp_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign can_load        = !vld_r || out_ready;
  assign out_valid       = vld_r;
  assign out_status      = res_r.status;
  assign out_frame_len   = res_r.frame_bytes;
  assign out_body_offset = res_r.body_offset;
  assign out_body_len    = res_r.body_bytes;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_i;
    end
  end

endmodule
